// ===== hw/rtl/hslrgb_pkg.sv =====
`default_nettype none

package hslrgb_pkg;

  // fraction bits of hue, saturation and lightness
  localparam int FRAC_BITS_DEF = 16;

  // output channel range
  localparam int CHAN_W   = 8;
  localparam int CHAN_MAX = 255;

  // hue sextants, in the order hue runs through them
  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYAN  = 3'd2,
    SEC_CYAN_BLUE = 3'd3,
    SEC_BLUE_MAG  = 3'd4,
    SEC_MAG_RED   = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hslrgb_scale.sv =====
`default_nettype none

// Last stage of one channel: sum * 255 >> (FRAC_BITS+1), clamped to 0..255, registered.
module hslrgb_scale
  import hslrgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [FRAC_BITS+3:0] sum_i,
  output      logic [CHAN_W-1:0]        chan_r
);

  logic [FRAC_BITS+10:0] prod;
  logic [9:0]            quot;
  logic [CHAN_W-1:0]     chan_nxt;

  always_comb begin
    // x*255 as (x<<8) - x; only the nonnegative range matters
    prod = {sum_i[FRAC_BITS+2:0], 8'b0} - {8'b0, sum_i[FRAC_BITS+2:0]};
    quot = prod[FRAC_BITS+10:FRAC_BITS+1];
    if (sum_i[FRAC_BITS+3] || sum_i == '0) begin
      chan_nxt = '0;
    end else if (quot > 10'(CHAN_MAX)) begin
      chan_nxt = CHAN_W'(CHAN_MAX);
    end else begin
      chan_nxt = quot[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
`default_nettype none

// Channel | dir | tdata fields, lowest bit up
// in_     | in  | hue [F-1:0], saturation [F+1 bits], lightness [F+1 bits], zero pad to bytes
// out_    | out | red [7:0], green [15:8], blue [23:16]
//
// Five-stage pipeline: clamp/deviation/sextant, chroma multiply, x multiply,
// channel placement and sum, scale-and-clamp into the output register.
// One pixel per clock while out_tready stays high; out_tvalid rises once the pixel
// has passed through the stage registers in the order above.
// Each full stage holds while its successor is stalled, so bubbles are
// squeezed out and nothing is dropped or repeated. rst_n clears only the valid bits.
module hsl_to_rgb_converter
  import hslrgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output      logic in_tready,
  // hue, saturation, lightness (lowest bit up), zero pad
  input  wire logic [((3*FRAC_BITS+9)/8)*8-1:0] in_tdata,
  output      logic out_tvalid,
  input  wire logic out_tready,
  // red, green, blue (lowest bit up)
  output      logic [3*CHAN_W-1:0] out_tdata
);

  localparam int F      = FRAC_BITS;
  localparam int NSTAGE = 5;
  localparam logic [F+1:0] ONE = (F+2)'(1) << F;

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] en;

  // handshake: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NSTAGE-1];

  // ---- stage 1: clamp, |2L-1|, sextant and weight
  logic [F-1:0] hue_in;
  logic [F:0]   sat_in, lgt_in;
  logic [F:0]   sat_nxt, lgt_nxt, omd_nxt, w_nxt;
  logic [F+1:0] l2, dev;
  logic [F+2:0] h6;
  logic [F-1:0] frac;
  sector_t      sec_nxt;

  assign hue_in = in_tdata[F-1:0];
  assign sat_in = in_tdata[2*F:F];
  assign lgt_in = in_tdata[3*F+1:2*F+1];

  always_comb begin
    sat_nxt = ({1'b0, sat_in} > ONE) ? ONE[F:0] : sat_in;
    lgt_nxt = ({1'b0, lgt_in} > ONE) ? ONE[F:0] : lgt_in;
    l2      = {lgt_nxt, 1'b0};
    dev     = (l2 >= ONE) ? (l2 - ONE) : (ONE - l2);
    omd_nxt = ONE[F:0] - dev[F:0];
    h6      = {3'b0, hue_in} * (F+3)'(6);
    sec_nxt = sector_t'(h6[F+2:F]);
    frac    = h6[F-1:0];
    w_nxt   = h6[F] ? (ONE[F:0] - {1'b0, frac}) : {1'b0, frac};
  end

  logic [F:0] s1_omd_r, s1_sat_r, s1_lgt_r, s1_w_r;
  sector_t    s1_sec_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_omd_r <= omd_nxt;
      s1_sat_r <= sat_nxt;
      s1_lgt_r <= lgt_nxt;
      s1_w_r   <= w_nxt;
      s1_sec_r <= sec_nxt;
    end
  end

  // ---- stage 2: chroma = (1-|2L-1|) * S
  logic [2*F+1:0] cprod;
  logic [F:0]     s2_chroma_r, s2_lgt_r, s2_w_r;
  sector_t        s2_sec_r;

  assign cprod = (2*F+2)'(s1_omd_r) * (2*F+2)'(s1_sat_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_chroma_r <= cprod[2*F:F];
      s2_lgt_r    <= s1_lgt_r;
      s2_w_r      <= s1_w_r;
      s2_sec_r    <= s1_sec_r;
    end
  end

  // ---- stage 3: x = chroma * w
  logic [2*F+1:0] xprod;
  logic [F:0]     s3_chroma_r, s3_x_r, s3_lgt_r;
  sector_t        s3_sec_r;

  assign xprod = (2*F+2)'(s2_chroma_r) * (2*F+2)'(s2_w_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_chroma_r <= s2_chroma_r;
      s3_x_r      <= xprod[2*F:F];
      s3_lgt_r    <= s2_lgt_r;
      s3_sec_r    <= s2_sec_r;
    end
  end

  // ---- stage 4: place chroma and x, add 2m = 2L - chroma
  logic [F:0]          pr, pg, pb;
  logic signed [F+3:0] base, sr_nxt, sg_nxt, sb_nxt;

  always_comb begin
    pr = '0;
    pg = '0;
    pb = '0;
    unique case (s3_sec_r)
      SEC_RED_YEL: begin
        pr = s3_chroma_r; pg = s3_x_r;
      end
      SEC_YEL_GRN: begin
        pr = s3_x_r;      pg = s3_chroma_r;
      end
      SEC_GRN_CYAN: begin
        pg = s3_chroma_r; pb = s3_x_r;
      end
      SEC_CYAN_BLUE: begin
        pg = s3_x_r;      pb = s3_chroma_r;
      end
      SEC_BLUE_MAG: begin
        pr = s3_x_r;      pb = s3_chroma_r;
      end
      default: begin
        pr = s3_chroma_r; pb = s3_x_r;
      end
    endcase
    base   = $signed({2'b0, s3_lgt_r, 1'b0}) - $signed({3'b0, s3_chroma_r});
    sr_nxt = $signed({2'b0, pr, 1'b0}) + base;
    sg_nxt = $signed({2'b0, pg, 1'b0}) + base;
    sb_nxt = $signed({2'b0, pb, 1'b0}) + base;
  end

  logic signed [F+3:0] s4_sr_r, s4_sg_r, s4_sb_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sr_r <= sr_nxt;
      s4_sg_r <= sg_nxt;
      s4_sb_r <= sb_nxt;
    end
  end

  // ---- stage 5: scale by 255, clamp, output register
  logic [CHAN_W-1:0] red_r, green_r, blue_r;

  hslrgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_red (
    .clk    (clk),
    .en     (en[4]),
    .sum_i  (s4_sr_r),
    .chan_r (red_r)
  );

  hslrgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_green (
    .clk    (clk),
    .en     (en[4]),
    .sum_i  (s4_sg_r),
    .chan_r (green_r)
  );

  hslrgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_blue (
    .clk    (clk),
    .en     (en[4]),
    .sum_i  (s4_sb_r),
    .chan_r (blue_r)
  );

  assign out_tdata = {blue_r, green_r, red_r};

endmodule

`default_nettype wire

// ===== dv/hsl_to_rgb_checker.sv =====
`timescale 1ns / 1ps

module hsl_to_rgb_checker
  import hslrgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IN_W      = ((3*FRAC_BITS+9)/8)*8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tready,
  // hue, saturation, lightness (lowest bit up), zero pad
  input  wire logic [IN_W-1:0] in_tdata,
  input  wire logic out_tvalid,
  input  wire logic out_tready,
  // red, green, blue (lowest bit up)
  input  wire logic [3*CHAN_W-1:0] out_tdata,
  output int mismatch_count,
  output int pending
);

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  pixel_t rgb_expected_q[$];
  int     result_idx;

  initial begin
    mismatch_count = 0;
    pending        = 0;
    result_idx     = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: result %0d: %s", $time, result_idx, msg);
  endtask

  // sum carries FRAC_BITS+1 fraction bits
  function automatic logic [CHAN_W-1:0] scale_channel(input longint sum2);
    longint v;
    if (sum2 <= 0) return '0;
    v = (sum2 * 255) >> (FRAC_BITS + 1);
    if (v > CHAN_MAX) v = CHAN_MAX;
    return v[CHAN_W-1:0];
  endfunction

  function automatic pixel_t hsl_to_rgb(input logic [FRAC_BITS-1:0] hue,
                                        input logic [FRAC_BITS:0] sat_raw,
                                        input logic [FRAC_BITS:0] light_raw);
    longint      s, l, dev, chroma, h6, f, w, x, pr, pg, pb, base;
    logic [2:0]  sec_bits;
    sector_t     sec;
    pixel_t      px;
    s = sat_raw;
    l = light_raw;
    if (s > UNIT) s = UNIT;
    if (l > UNIT) l = UNIT;
    dev    = (2*l >= UNIT) ? (2*l - UNIT) : (UNIT - 2*l);
    chroma = ((UNIT - dev) * s) >> FRAC_BITS;
    h6       = longint'(hue) * 6;
    sec_bits = 3'(h6 >> FRAC_BITS);
    sec      = sector_t'(sec_bits);
    f = h6 & (UNIT - 1);
    // falling edge of the ramp in odd sextants
    w = sec_bits[0] ? (UNIT - f) : f;
    x = (chroma * w) >> FRAC_BITS;
    pr = 0;
    pg = 0;
    pb = 0;
    case (sec)
      SEC_RED_YEL: begin
        pr = chroma;
        pg = x;
      end
      SEC_YEL_GRN: begin
        pr = x;
        pg = chroma;
      end
      SEC_GRN_CYAN: begin
        pg = chroma;
        pb = x;
      end
      SEC_CYAN_BLUE: begin
        pg = x;
        pb = chroma;
      end
      SEC_BLUE_MAG: begin
        pr = x;
        pb = chroma;
      end
      default: begin
        pr = chroma;
        pb = x;
      end
    endcase
    base = 2*l - chroma;
    px.red   = scale_channel(2*pr + base);
    px.green = scale_channel(2*pg + base);
    px.blue  = scale_channel(2*pb + base);
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        rgb_expected_q.push_back(hsl_to_rgb(in_tdata[FRAC_BITS-1:0],
                                            in_tdata[2*FRAC_BITS:FRAC_BITS],
                                            in_tdata[3*FRAC_BITS+1:2*FRAC_BITS+1]));
      if (out_tvalid && out_tready) begin
        got.red   = out_tdata[CHAN_W-1:0];
        got.green = out_tdata[2*CHAN_W-1:CHAN_W];
        got.blue  = out_tdata[3*CHAN_W-1:2*CHAN_W];
        if (rgb_expected_q.size() == 0) begin
          report_mismatch("transaction with no pixel pending");
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
        end
        result_idx++;
      end
    end
    pending = rgb_expected_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hslrgb_pkg::*;

  localparam int F      = FRAC_BITS_DEF;
  localparam int IN_W   = ((3*F+9)/8)*8;
  localparam logic [F:0] UNIT = (F+1)'(1) << F;
  localparam int N_RAND = 450;
  localparam logic [F:0] SAT_MAX = (F+1)'((1 << (F+1)) - 1);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [3*CHAN_W-1:0]   out_tdata;
  int                    mismatch_count;
  int                    pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hsl_to_rgb_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hsl_to_rgb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  task automatic send_pixel(input logic [F-1:0] hue, input logic [F:0] sat,
                            input logic [F:0] light, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({light, sat, hue});
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // mostly in range, with extremes and over-range codes mixed in
  function automatic logic [F:0] pick_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return UNIT;
    if (r < 30) return (F+1)'($urandom_range(0, SAT_MAX));
    return (F+1)'($urandom_range(0, UNIT));
  endfunction

  function automatic logic [F-1:0] pick_hue();
    int k;
    if ($urandom_range(0, 3) != 0) return F'($urandom);
    // land near a sextant boundary
    k = $urandom_range(1, 5);
    return F'((k*UNIT + 5)/6 + $urandom_range(0, 4) - 2);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(16'h0000, '0, '0, 1'b0);
    send_pixel(16'h0000, UNIT, UNIT/2, 1'b0);
    send_pixel(16'hFFFF, UNIT, UNIT/2, 1'b0);
    send_pixel(10922, UNIT, UNIT/2, 1'b0);
    send_pixel(10923, UNIT, UNIT/2, 1'b0);
    send_pixel(21845, UNIT, UNIT/2, 1'b0);
    send_pixel(21846, UNIT, UNIT/2, 1'b0);
    send_pixel(32767, UNIT, UNIT/2, 1'b0);
    send_pixel(32768, UNIT, UNIT/2, 1'b0);
    send_pixel(43690, UNIT, UNIT/2, 1'b0);
    send_pixel(43691, UNIT, UNIT/2, 1'b0);
    send_pixel(54613, UNIT, UNIT/2, 1'b0);
    send_pixel(54614, UNIT, UNIT/2, 1'b0);
    // gray, white, near black, near white
    send_pixel(12345, '0, 40000, 1'b0);
    send_pixel(16'h0000, UNIT, UNIT, 1'b0);
    send_pixel(30000, UNIT, 1, 1'b0);
    send_pixel(50000, UNIT, UNIT-1, 1'b0);
    // saturation / lightness codes above 1.0 saturate
    send_pixel(16'h0000, SAT_MAX, SAT_MAX, 1'b0);
    send_pixel(43690, SAT_MAX, UNIT/2, 1'b0);
    send_pixel(21845, UNIT, UNIT+1, 1'b0);
    send_pixel(16'hAAAA, 17'h15555, 17'h0AAAA, 1'b0);
    send_pixel(16'h5555, 17'h0AAAA, 17'h15555, 1'b0);

    for (int i = 0; i < N_RAND; i++) begin
      if (i == 300) begin
        // drain the pipe before carrying on
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait (pending == 0);
      end
      send_pixel(pick_hue(), pick_unit(), pick_unit(), (i/40)%3 == 1);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hsl_to_rgb_converter test passed");
    end else begin
      $display("hsl_to_rgb_converter test failed");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int results;
    int hold;
    results = 0;
    @(posedge rst_n);
    forever begin
      if (results == 150)
        hold = 64;   // long stall so the pipe fills and in_tready drops
      else if ((results/40)%3 == 1)
        hold = 0;
      else
        hold = $urandom_range(0, 3);
      repeat (hold) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      results++;
    end
  end

  initial begin
    #2_000_000;
    $display("hsl_to_rgb_converter test failed");
    $finish;
  end

endmodule
